### src/slfd_pkg.sv
// Shared types and constants for the sync-byte, length-prefixed frame receiver.
package slfd_pkg;

  localparam logic [7:0]  FRAME_SYNC    = 8'h80;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [8:0]  HEADER_BYTES  = 9'd2;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  rx_byte;
    logic        buffer_available;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [8:0]  position;
    logic [7:0]  byte_value;
    logic        frame_done;
    logic [8:0]  total_length;
  } result_t;

endpackage

### src/slfd_in_stage.sv
// Input register stage holding one item ahead of the frame logic.
module slfd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // rx_byte [7:0], buffer_available [8]
  input  logic              in_tuser,   // kind
  input  logic              advance,
  output logic              item_valid,
  output slfd_pkg::in_item_t item
);
  import slfd_pkg::*;

  logic     s1_v_r;
  logic     s1_v_nxt;
  in_item_t item_r;

  assign in_tready = !s1_v_r || advance;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_tready) begin
      s1_v_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind             <= item_kind_t'(in_tuser);
      item_r.rx_byte          <= in_tdata[7:0];
      item_r.buffer_available <= in_tdata[8];
    end
  end

  assign item_valid = s1_v_r;
  assign item       = item_r;

endmodule

### src/slfd_frame_ctl.sv
// Frame position tracking, timeout and completion logic with its state registers.
module slfd_frame_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               item_valid,
  input  slfd_pkg::in_item_t item,
  input  logic               commit,
  output slfd_pkg::result_t  res
);
  import slfd_pkg::*;

  logic [15:0] timeout_r;
  logic [8:0]  idx_r, idx_nxt;
  logic [8:0]  exp_r, exp_nxt;
  logic        open_r, open_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic        timed_out;
  logic [8:0]  pos;
  logic [8:0]  pos_inc;
  logic [8:0]  exp_eff;
  logic        done;

  always_comb begin
    idx_nxt     = idx_r;
    exp_nxt     = exp_r;
    open_nxt    = open_r;
    elapsed_nxt = elapsed_r;
    res         = '0;
    timed_out   = open_r && (elapsed_r > timeout_r);
    pos         = timed_out ? 9'd0 : idx_r;
    pos_inc     = pos + 9'd1;
    exp_eff     = (pos == 9'd1) ? (HEADER_BYTES + {1'b0, item.rx_byte}) : exp_r;
    done        = (pos_inc >= HEADER_BYTES) && (pos_inc == exp_eff);

    if (item.kind == KIND_TICK) begin
      if (open_r && (elapsed_r != ELAPSED_MAX)) begin
        elapsed_nxt = elapsed_r + 16'd1;
      end
    end else if (!item.buffer_available) begin
      idx_nxt = '0;
    end else begin
      if (timed_out) begin
        idx_nxt     = '0;
        open_nxt    = 1'b0;
        elapsed_nxt = '0;
      end
      if ((pos != 9'd0) || (item.rx_byte == FRAME_SYNC)) begin
        if (pos == 9'd0) begin
          open_nxt    = 1'b1;
          elapsed_nxt = '0;
        end
        exp_nxt = exp_eff;
        idx_nxt = pos_inc;
        if (done) begin
          idx_nxt     = '0;
          open_nxt    = 1'b0;
          elapsed_nxt = '0;
        end
        res.valid        = item_valid;
        res.position     = pos;
        res.byte_value   = item.rx_byte;
        res.frame_done   = done;
        res.total_length = done ? exp_eff : 9'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      idx_r     <= '0;
      exp_r     <= '0;
      open_r    <= 1'b0;
      elapsed_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (commit) begin
        idx_r     <= idx_nxt;
        exp_r     <= exp_nxt;
        open_r    <= open_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 9'd0) |-> open_r)
    else $error("byte index set while no frame is open");

  a_closed_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> (elapsed_r == 16'd0))
    else $error("elapsed counter running while no frame is open");

  a_done_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.frame_done) |-> ((res.position + 9'd1) == res.total_length))
    else $error("completing item is not at the last position");

  a_start_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && (res.position == 9'd0)) |-> (res.byte_value == FRAME_SYNC))
    else $error("frame started by a byte other than the sync byte");
`endif

endmodule

### src/slfd_out_reg.sv
// Output register holding one result item until the sink takes it.
module slfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  slfd_pkg::result_t res,
  input  logic              load,
  output logic              out_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);
  import slfd_pkg::*;

  logic    out_v_r;
  logic    out_v_nxt;
  result_t res_r;

  assign out_free = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_free) begin
      out_v_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r.total_length, res_r.byte_value, res_r.position};
  assign out_tlast  = res_r.frame_done;

endmodule

### src/sync_length_frame_deframer_core.sv
// Top level of the sync-byte, length-prefixed frame receiver.
// Each item is either a received byte or one timer tick; frames are the sync
// byte 0x80, a length byte L and L further bytes. Every byte taken into a frame
// comes out with its position, and the final byte raises tlast and carries the
// frame length L+2. Items pass through an input register, the combinational frame
// logic and an output register, so one item is taken per cycle and a result
// is offered once the output register has loaded it; the output register alone sets
// the pace when the sink stalls. The timeout register is written through cfg_wr_en.
module sync_length_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // timeout_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // rx_byte [7:0], buffer_available [8], zero [15:9]
  input  logic        in_tuser,      // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // position [8:0], byte_value [16:9],
                                     // total_length [25:17], zero [31:26]
  output logic        out_tlast      // frame_done
);
  import slfd_pkg::*;

  in_item_t item;
  logic     item_valid;
  result_t  res;
  logic     out_free;
  logic     advance;

  assign advance = item_valid && (!res.valid || out_free);

  slfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  slfd_frame_ctl u_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .commit      (advance),
    .res         (res)
  );

  slfd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .load       (advance && res.valid),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
